/* rtl/core/spr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_pkg: shared types and constants of the stack pattern remover
// Holds the controller/datapath command and status bundles, the register
// map indexes and the pattern byte selection.
// ----------------------------------------------------------------------------
package spr_pkg;

   // Longest pattern that the compare loop handles.
   localparam int PATTERN_MAX = 16;

   // Register indexes on the configuration port (address bits 4:3).
   localparam logic [1:0] REG_PATTERN_LEN  = 2'd0;
   localparam logic [1:0] REG_PATTERN_LOW  = 2'd1;
   localparam logic [1:0] REG_PATTERN_HIGH = 2'd2;

   // Item command codes.
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic [4:0]   len;
      logic [127:0] pattern;
   } spr_cfg_type;

   typedef struct packed {
      logic load_item;
      logic rd_issue;
      logic rd_capture;
      logic push_exec;
      logic cmp_init;
      logic cmp_step;
      logic rsp_load;
   } spr_cmd_type;

   typedef struct packed {
      logic full;
      logic check_needed;
      logic cmp_done;
      logic rsp_free;
   } spr_sts_type;

   // Byte j of the 16-byte pattern, byte 0 in the low bits.
   function automatic logic [7:0] spr_pat_byte(logic [127:0] pat, logic [3:0] j);
      return pat[{j, 3'b000} +: 8];
   endfunction

endpackage

/* rtl/core/spr_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_csr: configuration registers
// APB-style register file holding the pattern length and the two pattern words.
// ----------------------------------------------------------------------------
module spr_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [63:0]         pwdata,
   output logic [63:0]         prdata,
   output logic                pready,
   output spr_pkg::spr_cfg_type cfg
);
   import spr_pkg::*;

   logic [4:0]  len_ff,  len_in;
   logic [63:0] low_ff,  low_in;
   logic [63:0] high_ff, high_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:3];
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      len_in  = len_ff;
      low_in  = low_ff;
      high_in = high_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PATTERN_LEN:  len_in  = pwdata[4:0];
            REG_PATTERN_LOW:  low_in  = pwdata;
            REG_PATTERN_HIGH: high_in = pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= 5'd1;
         low_ff  <= 64'd0;
         high_ff <= 64'd0;
      end else begin
         len_ff  <= len_in;
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PATTERN_LEN:  prdata = {59'd0, len_ff};
         REG_PATTERN_LOW:  prdata = low_ff;
         REG_PATTERN_HIGH: prdata = high_ff;
         default:          prdata = 64'd0;
      endcase
   end

   assign cfg.len     = len_ff;
   assign cfg.pattern = {high_ff, low_ff};

endmodule

/* rtl/core/spr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_ctrl: sequencing state machine
// Steps one transaction at a time through read, push, compare and result.
// ----------------------------------------------------------------------------
module spr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_cmd,
   output logic                 req_stall,
   input  spr_pkg::spr_sts_type sts,
   output spr_pkg::spr_cmd_type cmd
);
   import spr_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_RD_ISSUE = 3'd1;
   localparam logic [2:0] S_RD_DATA  = 3'd2;
   localparam logic [2:0] S_PUSH     = 3'd3;
   localparam logic [2:0] S_CHECK    = 3'd4;
   localparam logic [2:0] S_CMP      = 3'd5;
   localparam logic [2:0] S_RESULT   = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in = (req_cmd == CMD_READ) ? S_RD_ISSUE : S_PUSH;
            end
         end
         S_RD_ISSUE: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_RD_DATA;
         end
         S_RD_DATA: begin
            cmd.rd_capture = 1'b1;
            state_in       = S_RESULT;
         end
         S_PUSH: begin
            cmd.push_exec = 1'b1;
            state_in      = sts.full ? S_RESULT : S_CHECK;
         end
         S_CHECK: begin
            if (sts.check_needed) begin
               cmd.cmp_init = 1'b1;
               state_in     = S_CMP;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_CMP: begin
            cmd.cmp_step = 1'b1;
            if (sts.cmp_done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/spr_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_dp: stack datapath
// Stack memory, depth counter, pipelined pattern compare and result register.
// ----------------------------------------------------------------------------
module spr_dp #(
   parameter int STACK_DEPTH = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  spr_pkg::spr_cmd_type cmd,
   output spr_pkg::spr_sts_type sts,
   input  spr_pkg::spr_cfg_type cfg,
   input  logic [7:0]           req_char_in,
   input  logic [9:0]           req_read_index,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_char_out,
   output logic [10:0]          rsp_depth,
   output logic                 rsp_removed,
   output logic                 rsp_overflow
);
   import spr_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int CW = (DW > 10) ? DW : 10;

   logic [7:0] stack_mem [STACK_DEPTH];

   logic [7:0]    char_ff;
   logic [9:0]    idx_ff;
   logic [DW-1:0] depth_ff,   depth_in;
   logic [DW-1:0] base_ff,    base_in;
   logic [4:0]    rd_cnt_ff,  rd_cnt_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [3:0]    cmp_idx_ff, cmp_idx_in;
   logic [7:0]    res_char_ff,     res_char_in;
   logic          res_removed_ff,  res_removed_in;
   logic          res_overflow_ff, res_overflow_in;
   logic          rsp_valid_ff,    rsp_valid_in;
   logic [7:0]    rsp_char_ff;
   logic [10:0]   rsp_depth_ff;
   logic          rsp_removed_ff;
   logic          rsp_overflow_ff;
   logic [7:0]    mem_q_ff;

   logic [4:0]    eff_len;
   logic          full;
   logic          in_range;
   logic          issue;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic          byte_match;
   logic          last_byte;

   // Lengths above the pattern register width saturate.
   assign eff_len  = (cfg.len > 5'(PATTERN_MAX)) ? 5'(PATTERN_MAX) : cfg.len;
   assign full     = (depth_ff == DW'(STACK_DEPTH));
   assign in_range = (CW'(idx_ff) < CW'(depth_ff));
   assign issue    = cmd.cmp_step && (rd_cnt_ff < eff_len);
   assign rd_en    = cmd.rd_issue || issue;
   assign rd_addr  = cmd.rd_issue ? AW'(idx_ff) : AW'(base_ff + DW'(rd_cnt_ff));
   assign wr_addr  = AW'(depth_ff);

   assign byte_match = (mem_q_ff == spr_pat_byte(cfg.pattern, cmp_idx_ff));
   assign last_byte  = ({1'b0, cmp_idx_ff} == (eff_len - 5'd1));

   assign sts.full         = full;
   assign sts.check_needed = (eff_len != 5'd0) && (depth_ff >= DW'(eff_len));
   assign sts.cmp_done     = cmp_vld_ff && (!byte_match || last_byte);
   assign sts.rsp_free     = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.push_exec && !full) begin
         stack_mem[wr_addr] <= char_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= stack_mem[rd_addr];
      end
   end

   always_comb begin
      depth_in        = depth_ff;
      base_in         = base_ff;
      rd_cnt_in       = rd_cnt_ff;
      cmp_vld_in      = cmp_vld_ff;
      cmp_idx_in      = cmp_idx_ff;
      res_char_in     = res_char_ff;
      res_removed_in  = res_removed_ff;
      res_overflow_in = res_overflow_ff;
      rsp_valid_in    = rsp_valid_ff;

      if (cmd.rd_capture) begin
         res_char_in     = in_range ? mem_q_ff : 8'd0;
         res_removed_in  = 1'b0;
         res_overflow_in = 1'b0;
      end

      if (cmd.push_exec) begin
         res_char_in     = 8'd0;
         res_removed_in  = 1'b0;
         res_overflow_in = full;
         if (!full) begin
            depth_in = depth_ff + DW'(1);
         end
      end

      if (cmd.cmp_init) begin
         base_in    = depth_ff - DW'(eff_len);
         rd_cnt_in  = 5'd0;
         cmp_vld_in = 1'b0;
      end

      if (cmd.cmp_step) begin
         cmp_vld_in = issue;
         cmp_idx_in = rd_cnt_ff[3:0];
         if (issue) begin
            rd_cnt_in = rd_cnt_ff + 5'd1;
         end
         if (cmp_vld_ff && byte_match && last_byte) begin
            depth_in       = base_ff;
            res_removed_in = 1'b1;
         end
      end

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         char_ff <= req_char_in;
         idx_ff  <= req_read_index;
      end
      base_ff         <= base_in;
      rd_cnt_ff       <= rd_cnt_in;
      cmp_idx_ff      <= cmp_idx_in;
      res_char_ff     <= res_char_in;
      res_removed_ff  <= res_removed_in;
      res_overflow_ff <= res_overflow_in;
      if (cmd.rsp_load) begin
         rsp_char_ff     <= res_char_ff;
         rsp_depth_ff    <= 11'(depth_ff);
         rsp_removed_ff  <= res_removed_ff;
         rsp_overflow_ff <= res_overflow_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_depth    = rsp_depth_ff;
   assign rsp_removed  = rsp_removed_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

/* rtl/core/stack_pattern_remover.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_pattern_remover: stack-based removal of a configured byte pattern
// Pushes bytes onto a stack and pops the top pattern_len entries whenever
// they equal the configured pattern, so removals cascade across pushes.
// Read transactions return one stack entry by index plus the current depth.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   req_*     in         req_valid / req_stall  cmd, char_in, read_index
//   rsp_*     out        rsp_valid / rsp_stall  char_out, depth, removed, overflow
//   APB       in/out     psel, penable, pready  paddr, pwdata, prdata
//
// One transaction at a time. A read runs the issue, data and result states, a push
// onto a full stack the push and result states, a push with no compare also check,
// and a compared push also a compare of n bytes, n being pattern_len saturated at 16.
// The compare reads one entry per cycle through the single read port and stops at
// the first mismatch. Reset is synchronous, active high and empties the stack.
// A stalled result waits in the output register while the next transaction runs.
//
module stack_pattern_remover #(
   parameter int STACK_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_char_in,
   input  logic [9:0]  req_read_index,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_char_out,
   output logic [10:0] rsp_depth,
   output logic        rsp_removed,
   output logic        rsp_overflow,
   // Configuration port.
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   import spr_pkg::*;

   spr_cfg_type cfg;
   spr_cmd_type cmd;
   spr_sts_type sts;

   // Pattern length and the two pattern words.
   spr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The controller only sees the request handshake, the command bit and datapath status;
   // every data movement is a command to the datapath.
   spr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Stack memory, depth counter, compare pipeline and output register.
   spr_dp #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .cfg            (cfg),
      .req_char_in    (req_char_in),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_char_out   (rsp_char_out),
      .rsp_depth      (rsp_depth),
      .rsp_removed    (rsp_removed),
      .rsp_overflow   (rsp_overflow)
   );

endmodule

/* rtl/core/spr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_checker: port-level assertions for the stack pattern remover
// Watches the top-level ports and is attached by a bind statement.
// ----------------------------------------------------------------------------
module spr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_char_out,
   input logic [10:0] rsp_depth,
   input logic        rsp_removed,
   input logic        rsp_overflow
);

   // One transaction at a time: accepting one makes the block busy.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while a transaction was in flight");

   // A push is either dropped or compared, never both.
   a_removed_overflow_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_removed && rsp_overflow))
      else $error("removed and overflow flagged together");

   // Removed and overflowed push results carry no character.
   a_push_char_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_removed || rsp_overflow)) |-> (rsp_char_out == 8'd0))
      else $error("push result carries a character");

   // A stalled result holds its valid, depth and character.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_depth)
                                    && $stable(rsp_char_out)))
      else $error("stalled result changed");

endmodule

bind stack_pattern_remover spr_checker u_spr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_char_out (rsp_char_out),
   .rsp_depth    (rsp_depth),
   .rsp_removed  (rsp_removed),
   .rsp_overflow (rsp_overflow)
);

/* tb/sv/stack_pattern_remover_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_pattern_remover_tb: self-checking bench for the stack pattern remover
// Pushes and reads are driven through the request channel under random
// gaps, and results are taken under random stalls. A predictor keeps its own
// copy of the stack and the pattern registers, and each result is checked
// field by field against it. The run covers directed corner cases, several
// random pattern settings and a final fill of the stack up to overflow.
// ----------------------------------------------------------------------------
module stack_pattern_remover_tb;
   import spr_pkg::*;

   localparam int unsigned STACK_SIZE = 1024;
   // Address bits 4:3 equal to three select no register, so a write there
   // must leave the pattern alone.
   localparam logic [1:0] REG_UNUSED = 2'd3;
   // Cycles to let pass once nothing is expected. The longest transaction
   // is a full sixteen-entry compare.
   localparam int unsigned DRAIN_CYCLES = 40;

   typedef struct packed {
      logic       cmd;
      logic [7:0] char_in;
      logic [9:0] read_index;
   } stack_op_type;

   typedef struct packed {
      logic [7:0]  char_out;
      logic [10:0] depth;
      logic        removed;
      logic        overflow;
   } stack_result_type;

   logic        clock = 1'b1;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = CMD_PUSH;
   logic [7:0]  req_char_in = 8'h00;
   logic [9:0]  req_read_index = 10'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_char_out;
   logic [10:0] rsp_depth;
   logic        rsp_removed;
   logic        rsp_overflow;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = 5'd0;
   logic [63:0] pwdata = 64'd0;
   logic [63:0] prdata;
   logic        pready;

   // Transactions waiting to be driven, and results the predictor expects.
   stack_op_type     pending_ops[$];
   stack_result_type expected_results[$];

   // Predictor state: its own stack, depth and pattern registers.
   logic [7:0]   model_stack [STACK_SIZE];
   int unsigned  model_depth = 0;
   logic [4:0]   model_len = 5'd1;
   logic [127:0] model_pattern = '0;

   int unsigned error_count = 0;
   int unsigned sent_count = 0;
   int unsigned taken_count = 0;
   int unsigned req_gap = 0;
   int unsigned rsp_hold = 0;

   stack_pattern_remover #(
      .STACK_DEPTH(STACK_SIZE)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_char_in(req_char_in),
      .req_read_index(req_read_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_char_out(rsp_char_out),
      .rsp_depth(rsp_depth),
      .rsp_removed(rsp_removed),
      .rsp_overflow(rsp_overflow),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Number of idle cycles for one transaction. Every fourth stretch of 48
   // transactions runs with no idling at all, so back-to-back traffic is
   // exercised as well.
   function automatic int unsigned draw_wait(int unsigned seq);
      if ((seq / 48) % 4 == 1) begin
         return 0;
      end
      return $urandom_range(0, 6);
   endfunction

   // Applies one accepted transaction to the predicted stack and queues the
   // result it must produce. A push onto a full stack is dropped without a
   // compare; otherwise the top entries are compared with the pattern, whose
   // length saturates at sixteen and disables removal when zero.
   function automatic void apply_to_stack(stack_op_type op);
      stack_result_type res;
      int unsigned      span;
      int unsigned      base;
      bit               hit;
      res = '0;
      if (op.cmd == CMD_READ) begin
         if (op.read_index < model_depth) begin
            res.char_out = model_stack[op.read_index];
         end
      end else if (model_depth >= STACK_SIZE) begin
         res.overflow = 1'b1;
      end else begin
         span = (model_len > PATTERN_MAX) ? PATTERN_MAX : model_len;
         model_stack[model_depth] = op.char_in;
         model_depth++;
         if (span != 0 && model_depth >= span) begin
            base = model_depth - span;
            hit = 1'b1;
            for (int unsigned j = 0; j < span; j++) begin
               if (model_stack[base + j] != model_pattern[8 * j +: 8]) begin
                  hit = 1'b0;
               end
            end
            if (hit) begin
               model_depth = base;
               res.removed = 1'b1;
            end
         end
      end
      res.depth = model_depth[10:0];
      expected_results.insert(expected_results.size(), res);
   endfunction

   // Request driver. A new transaction is presented only when the previous
   // one has been taken, and the payload holds while the block stalls.
   always @(posedge clock) begin
      stack_op_type op;
      logic         slot_free;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         slot_free = !req_valid || !req_stall;
         if (req_valid && !req_stall) begin
            op.cmd = req_cmd;
            op.char_in = req_char_in;
            op.read_index = req_read_index;
            apply_to_stack(op);
         end
         if (slot_free) begin
            if (req_gap != 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
               op = pending_ops.pop_front();
               req_cmd <= op.cmd;
               req_char_in <= op.char_in;
               req_read_index <= op.read_index;
               req_valid <= 1'b1;
               req_gap <= draw_wait(sent_count);
               sent_count <= sent_count + 1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Each taken result is compared with the oldest
   // expectation, and a random stall follows it.
   always @(posedge clock) begin
      stack_result_type want;
      int unsigned      hold;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold <= 0;
      end else begin
         hold = rsp_hold;
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result char_out=%h depth=%0d removed=%b overflow=%b",
                        $time, rsp_char_out, rsp_depth, rsp_removed, rsp_overflow);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_char_out !== want.char_out) begin
                  $display("%0t: char_out expected %h actual %h",
                           $time, want.char_out, rsp_char_out);
                  error_count++;
               end
               if (rsp_depth !== want.depth) begin
                  $display("%0t: depth expected %0d actual %0d",
                           $time, want.depth, rsp_depth);
                  error_count++;
               end
               if (rsp_removed !== want.removed) begin
                  $display("%0t: removed expected %b actual %b",
                           $time, want.removed, rsp_removed);
                  error_count++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $display("%0t: overflow expected %b actual %b",
                           $time, want.overflow, rsp_overflow);
                  error_count++;
               end
            end
            hold = draw_wait(taken_count + 17);
            taken_count <= taken_count + 1;
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            rsp_hold <= hold - 1;
         end else begin
            rsp_stall <= 1'b0;
            rsp_hold <= 0;
         end
      end
   end

   task automatic queue_push(input logic [7:0] ch);
      stack_op_type op;
      op.cmd = CMD_PUSH;
      op.char_in = ch;
      op.read_index = 10'($urandom_range(0, 1023));
      pending_ops.insert(pending_ops.size(), op);
   endtask

   task automatic queue_read(input logic [9:0] idx);
      stack_op_type op;
      op.cmd = CMD_READ;
      op.char_in = 8'($urandom_range(0, 255));
      op.read_index = idx;
      pending_ops.insert(pending_ops.size(), op);
   endtask

   // Waits until every queued transaction has been taken and every result
   // has arrived, then lets the block drain. Sampling at the falling edge
   // keeps this free of races with the driver.
   task automatic wait_quiet();
      while (pending_ops.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // One register write: setup cycle, then access cycle until pready. The
   // predictor copy is updated at the edge where the block takes the write.
   task automatic csr_write(input logic [1:0] reg_index, input logic [63:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_index, 3'b000};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (reg_index)
         REG_PATTERN_LEN: begin
            model_len = value[4:0];
         end
         REG_PATTERN_LOW: begin
            model_pattern[63:0] = value;
         end
         REG_PATTERN_HIGH: begin
            model_pattern[127:64] = value;
         end
         default: begin
         end
      endcase
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // One random phase under a fresh pattern. The pattern bytes come from a
   // four-letter alphabet so that random pushes also complete it now and
   // then. Most of the traffic is whole patterns, some with one corrupted
   // byte, and nested patterns that only vanish once the outer one is
   // finished, which makes removals cascade.
   task automatic run_pattern_phase(input logic [4:0] len_value, input int unsigned quota);
      logic [7:0]   letter;
      logic [7:0]   pat [16];
      logic [127:0] word;
      int unsigned  span;
      int unsigned  added;
      int unsigned  pick;
      int unsigned  bad;
      int unsigned  cut;
      letter = 8'($urandom_range(0, 255));
      for (int k = 0; k < 16; k++) begin
         pat[k] = letter + 8'($urandom_range(0, 3));
         word[8 * k +: 8] = pat[k];
      end
      wait_quiet();
      csr_write(REG_PATTERN_LEN, {59'd0, len_value});
      csr_write(REG_PATTERN_LOW, word[63:0]);
      csr_write(REG_PATTERN_HIGH, word[127:64]);
      span = (len_value > PATTERN_MAX) ? PATTERN_MAX : len_value;
      // With removal disabled the sequences still use some pattern length.
      if (span == 0) begin
         span = 4;
      end
      added = 0;
      while (added < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            bad = ($urandom_range(0, 6) == 0) ? $urandom_range(0, span - 1) : span;
            for (int unsigned k = 0; k < span; k++) begin
               queue_push((k == bad) ? ~pat[k] : pat[k]);
            end
            added += span;
         end else if (pick < 55) begin
            cut = $urandom_range(0, span - 1);
            for (int unsigned k = 0; k < cut; k++) begin
               queue_push(pat[k]);
            end
            for (int unsigned k = 0; k < span; k++) begin
               queue_push(pat[k]);
            end
            for (int unsigned k = cut; k < span; k++) begin
               queue_push(pat[k]);
            end
            added += 2 * span;
         end else if (pick < 72) begin
            queue_push(letter + 8'($urandom_range(0, 3)));
            added++;
         end else if (pick < 82) begin
            queue_push(8'($urandom_range(0, 255)));
            added++;
         end else begin
            queue_read(10'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                       : $urandom_range(0, 40)));
            added++;
         end
      end
   endtask

   initial begin
      int unsigned fill;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset state: a one-byte pattern of zero. A zero push vanishes at
      // once, and reads at and beyond the depth return zero.
      queue_push(8'h00);
      queue_push(8'hFF);
      queue_push(8'h80);
      queue_read(10'd0);
      queue_read(10'd1);
      queue_read(10'd2);
      queue_read(10'd1023);
      queue_push(8'h00);

      // Pattern "abc": a partial match under a complete one, so the last
      // push removes the outer pattern through the stacked prefix.
      wait_quiet();
      csr_write(REG_PATTERN_LEN, 64'd3);
      csr_write(REG_PATTERN_LOW, {32'($urandom), 32'($urandom) & 32'hFF000000 | 32'h00636261});
      csr_write(REG_PATTERN_HIGH, {32'($urandom), 32'($urandom)});
      queue_push(8'h61);
      queue_push(8'h62);
      queue_push(8'h61);
      queue_push(8'h62);
      queue_push(8'h63);
      queue_push(8'h63);
      queue_read(10'd1);

      // A zero length never removes anything, and a write to the unused
      // address must not disturb it.
      wait_quiet();
      csr_write(REG_PATTERN_LEN, 64'd0);
      csr_write(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_push(8'h00);
      queue_push(8'h63);
      queue_read(10'd3);

      // Random phases, including the shortest pattern, the longest one, a
      // disabled one and a length that saturates to the longest.
      run_pattern_phase(5'd1, 80);
      run_pattern_phase(5'd16, 80);
      run_pattern_phase(5'd0, 60);
      run_pattern_phase(5'd31, 80);
      run_pattern_phase(5'd2, 80);
      for (int p = 0; p < 3; p++) begin
         run_pattern_phase(5'($urandom_range(1, 16)), 80);
      end

      // Fill the stack to the top with bytes that cannot match an all-zero
      // pattern, then push onto the full stack. This phase comes last since
      // a full stack can never shrink again.
      wait_quiet();
      csr_write(REG_PATTERN_LEN, 64'd16);
      csr_write(REG_PATTERN_LOW, 64'd0);
      csr_write(REG_PATTERN_HIGH, 64'd0);
      fill = STACK_SIZE - model_depth;
      for (int unsigned k = 0; k < fill; k++) begin
         queue_push(8'($urandom_range(1, 255)));
         if ($urandom_range(0, 9) == 0) begin
            queue_read(10'($urandom_range(0, 1023)));
         end
      end
      queue_push(8'h00);
      queue_push(8'hFF);
      for (int k = 0; k < 4; k++) begin
         queue_push(8'($urandom_range(0, 255)));
      end
      queue_read(10'd0);
      queue_read(10'd1023);
      for (int k = 0; k < 20; k++) begin
         queue_read(10'($urandom_range(0, 1023)));
      end

      wait_quiet();
      if (error_count == 0) begin
         $display("stack_pattern_remover_tb passed");
      end else begin
         $display("stack_pattern_remover_tb failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #1_000_000;
      $display("stack_pattern_remover_tb failed");
      $finish;
   end

endmodule
